FILE: rtl/bounded_array_set_top_assert.svh
// ----------------------------------------------------------------------------
// Bounded array set assertion macros
// Concurrent checks on the aclk domain, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_SET_TOP_ASSERT_SVH
`define BOUNDED_ARRAY_SET_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define BAS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("bounded_array_set: invariant violated");

// A consequence that must hold in the same cycle as its trigger.
`define BAS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bounded_array_set: same-cycle implication violated");

// A consequence that must hold in the cycle after its trigger.
`define BAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bounded_array_set: next-cycle implication violated");

`endif

FILE: rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array set package
// Request and response types, operation codes, cell commands and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package bas_pkg;

    // Fixed field widths of the request and response channels.
    localparam int VALUE_W = 32;
    localparam int SIZE_W  = 5;

    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_CONTAINS = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
    } bas_req_t;

    typedef struct packed {
        logic                ok;
        logic [SIZE_W-1:0]   size_after;
    } bas_resp_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic lookup;   // capture the compare result for the current request
        logic shift;    // cells at or above the hit slot take their upper neighbour
        logic append;   // the cell at the live count stores the request value
    } bas_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/bas_cell.sv
// ----------------------------------------------------------------------------
// Bounded array set storage cell
// Holds one entry, compares it against the broadcast value and, on removal,
// takes the entry of its upper neighbour so that the live entries stay packed.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_cell
    import bas_pkg::*;
#(
    parameter int VB    = 32,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  wire logic              aclk,
    input  wire bas_cmd_t          cmd_i,
    input  wire logic [VB-1:0]     value_i,
    input  wire logic [CNT_W-1:0]  count_i,
    input  wire logic [IDX_W-1:0]  slot_i,
    input  wire logic [VB-1:0]     neighbour_i,
    output logic      [VB-1:0]     entry_o,
    output logic                   hit_o
);

    logic [VB-1:0] entry_reg;
    logic          hit_reg;
    logic          live;

    // The cell holds a live entry only while its index is below the count.
    assign live = CNT_W'(INDEX) < count_i;

    // Compare result, captured in the lookup cycle.
    always_ff @(posedge aclk) begin
        if (cmd_i.lookup) begin
            hit_reg <= live && (entry_reg == value_i);
        end
    end

    // Entry update: compaction after a removal, or a new entry at the tail.
    always_ff @(posedge aclk) begin
        if (cmd_i.shift && (IDX_W'(INDEX) >= slot_i)) begin
            entry_reg <= neighbour_i;
        end else if (cmd_i.append && (CNT_W'(INDEX) == count_i)) begin
            entry_reg <= value_i;
        end
    end

    assign entry_o = entry_reg;
    assign hit_o   = hit_reg;

endmodule

`default_nettype wire

FILE: rtl/bounded_array_set_top.sv
// ----------------------------------------------------------------------------
// Bounded array set, top level
// Flow: an accepted request goes to the lookup state, then the update state.
// A new request is accepted as the previous one completes its update.
// Every cell compares in parallel; the update writes the response register.
// A response waiting on m_ready stalls the next update and with it new acceptance.
// Reset: synchronous, active low; clears the live count and the handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_array_set_top_assert.svh"

module bounded_array_set_top
    import bas_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire bas_req_t  s_req,
    output logic           m_valid,
    input  wire logic      m_ready,
    output bas_resp_t      m_resp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    kind_t                kind_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                 m_valid_reg, m_valid_next;
    bas_resp_t            resp_reg;

    bas_cmd_t             cmd;
    logic [VALUE_BITS-1:0] entries [CAPACITY];
    logic [CAPACITY-1:0]  hit_vec;
    logic [IDX_W-1:0]     slot;
    logic                 any_hit;
    logic                 full;
    logic                 upd_go;
    logic                 s_fire;
    logic                 ok;

    // The update cycle completes once the response register is free.
    assign upd_go  = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_IDLE) || upd_go;
    assign s_fire  = s_valid && s_ready;
    assign full    = count_reg == CNT_W'(CAPACITY);

    // Locate the hit. Values are distinct, so at most one cell reports a hit.
    always_comb begin
        slot    = '0;
        any_hit = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit_vec[i]) begin
                slot    = slot | IDX_W'(i);
                any_hit = 1'b1;
            end
        end
    end

    // Operation decision and cell commands for the lookup and update cycles.
    always_comb begin
        cmd        = '0;
        cmd.lookup = state_reg == ST_LOOK;
        count_next = count_reg;
        ok         = 1'b0;
        unique case (kind_reg)
            KIND_ADD: begin
                ok = !full && !any_hit;
                if (upd_go && ok) begin
                    cmd.append = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                ok = any_hit;
                if (upd_go && ok) begin
                    cmd.shift  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_CONTAINS: begin
                ok = any_hit;
            end
            KIND_CLEAR: begin
                ok = 1'b1;
                if (upd_go) begin
                    count_next = '0;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Sequencer: idle, lookup, update.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (s_fire) begin
                    state_next = ST_LOOK;
                end else if (upd_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (upd_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request and response payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg  <= s_req.kind;
            value_reg <= VALUE_BITS'(s_req.value);
        end
        if (upd_go) begin
            resp_reg.ok         <= ok;
            resp_reg.size_after <= SIZE_W'(count_next);
        end
    end

    // Row of storage cells; each above the first passes its entry down to the cell below.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_BITS-1:0] neighbour;

        if (g == CAPACITY - 1) begin : g_last
            assign neighbour = entries[g];
        end else begin : g_inner
            assign neighbour = entries[g+1];
        end

        bas_cell #(
            .VB    (VALUE_BITS),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .aclk        (aclk),
            .cmd_i       (cmd),
            .value_i     (value_reg),
            .count_i     (count_reg),
            .slot_i      (slot),
            .neighbour_i (neighbour),
            .entry_o     (entries[g]),
            .hit_o       (hit_vec[g])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_resp  = resp_reg;

    // Assertions.
    `BAS_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `BAS_ASSERT_IMPLIES(a_single_hit, state_reg == ST_UPD, $onehot0(hit_vec))
    `BAS_ASSERT_NEXT(a_accept_lookup, s_valid && s_ready, state_reg == ST_LOOK)
    `BAS_ASSERT_NEXT(a_update_resp, upd_go, m_valid_reg)

endmodule

`default_nettype wire

FILE: tb/bounded_array_set_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded array set response checker
// Watches the request and response channels, keeps its own copy of the set and its live
// count, works out the response that each accepted request should give and
// compares every accepted response with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module bounded_array_set_checker
    import bas_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire bas_req_t  s_req,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire bas_resp_t m_resp,
    output int unsigned    fail_count,
    output int unsigned    outstanding
);

    // Predicted set contents; only slots below member_count are meaningful.
    logic [VALUE_W-1:0] members [CAPACITY];
    int unsigned        member_count = 0;
    bas_resp_t          expected_resp [$];
    int unsigned        resp_index = 0;
    int unsigned        mismatches = 0;
    int unsigned        pending_count = 0;

    assign fail_count  = mismatches;
    assign outstanding = pending_count;

    // Every mismatch is counted and printed on one line.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t ns: response %0d: %s: got %0h, expected %0h",
                 $time, resp_index, what, got, want);
    endtask

    // Slot holding v among the live entries, or -1 when it is absent.
    function automatic int find_member(logic [VALUE_W-1:0] v);
        for (int i = 0; i < member_count; i++) begin
            if (members[i] == v)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the predicted set and returns its response.
    function automatic bas_resp_t apply_request(bas_req_t req);
        bas_resp_t resp;
        int        slot;
        slot    = find_member(req.value);
        resp.ok = 1'b0;
        case (req.kind)
            KIND_ADD: begin
                if (member_count < CAPACITY && slot < 0) begin
                    members[member_count] = req.value;
                    member_count++;
                    resp.ok = 1'b1;
                end
            end
            KIND_REMOVE: begin
                // The last live entry fills the hole left by the removed one.
                if (slot >= 0) begin
                    member_count--;
                    members[slot] = members[member_count];
                    resp.ok = 1'b1;
                end
            end
            KIND_CONTAINS: begin
                resp.ok = (slot >= 0);
            end
            KIND_CLEAR: begin
                member_count = 0;
                resp.ok = 1'b1;
            end
        endcase
        resp.size_after = SIZE_W'(member_count);
        return resp;
    endfunction

    // Responses are checked before new requests are predicted, since a
    // response can never belong to a request accepted at the same edge.
    always @(posedge aclk) begin : monitor
        bas_resp_t want;
        if (!aresetn) begin
            member_count = 0;
            expected_resp.delete();
        end else begin
            if (m_valid && m_ready) begin
                resp_index++;
                if (expected_resp.size() == 0) begin
                    report_mismatch("response with no request outstanding",
                                    32'(m_resp), 32'h0);
                end else begin
                    want = expected_resp.pop_front();
                    if (m_resp.ok !== want.ok)
                        report_mismatch("ok", 32'(m_resp.ok), 32'(want.ok));
                    if (m_resp.size_after !== want.size_after)
                        report_mismatch("size_after", 32'(m_resp.size_after),
                                        32'(want.size_after));
                end
            end
            if (s_valid && s_ready)
                expected_resp.insert(expected_resp.size(), apply_request(s_req));
        end
        pending_count = expected_resp.size();
    end

endmodule

FILE: tb/bounded_array_set_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded array set regression
// Drives a directed run over the corner cases of add, remove, contains and
// clear, then phases of random requests drawn mostly from a small value pool
// so that the set fills, overflows and drains. Both channels idle at random;
// one long response stall backs the block up. The checker judges responses.
// ----------------------------------------------------------------------------
module bounded_array_set_top_tb;
    import bas_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int RANDOM_ITEMS     = 1000;
    localparam int PHASE_ITEMS      = 100;
    localparam int POOL_SIZE        = 24;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    bas_req_t    s_req;
    logic        m_valid;
    logic        m_ready;
    bas_resp_t   m_resp;
    int unsigned fail_count;
    int unsigned outstanding;

    // Phase controls shared by the request and response sides.
    logic calm      = 1'b0;
    logic long_hold = 1'b0;

    logic [VALUE_W-1:0] pool [POOL_SIZE];

    bounded_array_set_top #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_W)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_resp  (m_resp)
    );

    bounded_array_set_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_resp      (m_resp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Idle length: mostly none, often short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one request after an optional gap and returns at the falling
    // edge after it has been accepted.
    task automatic send_request(kind_t kind, logic [VALUE_W-1:0] value);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= '{kind: kind, value: value};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Response side: random ready pattern, or one long hold when asked.
    initial begin : response_sink
        int unsigned span;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                long_hold = 1'b0;
            end else begin
                span = idle_len();
                if (span == 0) begin
                    m_ready <= 1'b1;
                    span = $urandom_range(1, 6);
                end else begin
                    m_ready <= 1'b0;
                end
                repeat (span) @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        int unsigned        r;
        int unsigned        phase;
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               filling;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req   = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Operations on an empty set.
        send_request(KIND_CLEAR, '0);
        send_request(KIND_CONTAINS, '0);
        send_request(KIND_REMOVE, '0);
        // Extreme values, a duplicate add and lookups that hit and miss.
        send_request(KIND_ADD, '0);
        send_request(KIND_ADD, '1);
        send_request(KIND_ADD, '0);
        send_request(KIND_CONTAINS, '1);
        send_request(KIND_CONTAINS, 32'h5555_5555);
        send_request(KIND_REMOVE, 32'hAAAA_AAAA);
        send_request(KIND_REMOVE, '0);
        // Fill to capacity, then try one more add.
        for (int i = 1; i < CAPACITY; i++)
            send_request(KIND_ADD, VALUE_W'(i) * 32'h0101_0101);
        send_request(KIND_ADD, 32'h1234_5678);
        // Remove from the first slot of a full set, then clear it.
        send_request(KIND_REMOVE, '1);
        send_request(KIND_CONTAINS, 32'h0F0F_0F0F);
        send_request(KIND_CLEAR, '0);

        // Random phases alternate between filling and draining the set.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                phase   = n / PHASE_ITEMS;
                filling = (phase % 2 == 0);
                calm    = (phase % 4 == 3);
                foreach (pool[i])
                    pool[i] = $urandom();
                // Hold responses off while requests keep coming, so that the
                // block backs up and stops accepting.
                if (phase == 3)
                    long_hold = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < (filling ? 55 : 20))
                kind = KIND_ADD;
            else if (r < (filling ? 70 : 65))
                kind = KIND_REMOVE;
            else if (r < (filling ? 99 : 97))
                kind = KIND_CONTAINS;
            else
                kind = KIND_CLEAR;
            value = ($urandom_range(0, 9) == 0) ? VALUE_W'($urandom())
                                                : pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(kind, value);
        end
        s_valid <= 1'b0;

        // Drain, let the block settle, then give the verdict.
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("bounded_array_set_top regression: pass");
        else
            $display("bounded_array_set_top regression: fail");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("bounded_array_set_top regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bas_pkg.sv
rtl/bas_cell.sv
rtl/bounded_array_set_top.sv
tb/bounded_array_set_checker.sv
tb/bounded_array_set_top_tb.sv
